FILE: rtl/core/sva_pkg.sv
package sva_pkg;

    // fixed field widths
    localparam int SAMPLE_W   = 32;
    localparam int WHOLE_W    = 63;
    localparam int FRAC_OUT_W = 16;
    localparam int STATUS_W   = 2;

    // accumulator widths
    localparam int CNT_W = 17;
    localparam int SUM_W = 48;
    localparam int SQ_W  = 80;
    // n*sum_sq - sum^2 stays below 2^97
    localparam int ACC_W = 97;
    // shared multiplier operand width
    localparam int MUL_W = 32;

    localparam int MAX_SAMPLES = 65536;
    localparam int FRAC_BITS   = 16;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FEW      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EXCEEDED = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } sva_in_t;

    typedef struct packed {
        logic [WHOLE_W-1:0]    variance_whole;
        logic [FRAC_OUT_W-1:0] variance_fraction;
        logic [STATUS_W-1:0]   status;
    } sva_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sva_div_stat_t;

endpackage

FILE: rtl/core/sva_divider.sv
module sva_divider #(
    parameter int NUM_W = sva_pkg::ACC_W + sva_pkg::FRAC_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [NUM_W-1:0]             numerator,
    input  logic [sva_pkg::MUL_W-1:0]    divisor,
    output sva_pkg::sva_div_stat_t       stat,
    output logic [NUM_W-1:0]             quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int DW    = sva_pkg::MUL_W;

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] num_next;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    rem_next;
    logic [DW:0]      trial;
    logic [DW:0]      trial_diff;
    logic             qbit;

    // one restoring step: bring down the next numerator bit
    always_comb begin
        trial      = {rem_reg, num_reg[NUM_W-1]};
        trial_diff = trial - {1'b0, divisor};
        qbit       = (trial >= {1'b0, divisor});
        rem_next   = qbit ? trial_diff[DW-1:0] : trial[DW-1:0];
        num_next   = {num_reg[NUM_W-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // quotient bits shift in as numerator bits shift out
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= numerator;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = num_reg;

endmodule

FILE: rtl/core/sample_variance_accumulator.sv
// channel  | direction | ports                       | beat carries
// ---------+-----------+-----------------------------+-----------------------------------
// s_       | in        | s_valid, s_ready, s_item    | one 32-bit sample and a last flag
// m_       | out       | m_valid, m_ready, m_item    | variance whole/fraction and status
//
// a sample beat is taken, squared, then accumulated; one beyond the limit is only taken and dropped
// the last beat of a set of two or more then runs 7 products through the shared
// 32x32 multiplier (S_MUL, then S_MAC for each), then one quotient bit per cycle in the divider
// aresetn is synchronous and clears the accumulators, sequencer and output valid
// a finished result sits in the output register; new samples are taken meanwhile, and
// the sequencer only holds when the next result is ready and the old one is still unread
module sample_variance_accumulator #(
    parameter int FRAC_BITS = sva_pkg::FRAC_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sva_pkg::sva_in_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output sva_pkg::sva_out_t m_item
);

    localparam int CNT_W = sva_pkg::CNT_W;
    localparam int SUM_W = sva_pkg::SUM_W;
    localparam int SQ_W  = sva_pkg::SQ_W;
    localparam int ACC_W = sva_pkg::ACC_W;
    localparam int MUL_W = sva_pkg::MUL_W;
    localparam int NUM_W = ACC_W + FRAC_BITS;
    localparam int FO_W  = sva_pkg::FRAC_OUT_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SQ    = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_MAC   = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    // product steps: n*sum_sq limbs, sum^2 limbs, then the denominator
    localparam logic [2:0] STEP_NS0 = 3'd0;
    localparam logic [2:0] STEP_NS1 = 3'd1;
    localparam logic [2:0] STEP_NS2 = 3'd2;
    localparam logic [2:0] STEP_SS0 = 3'd3;
    localparam logic [2:0] STEP_SS1 = 3'd4;
    localparam logic [2:0] STEP_SS2 = 3'd5;
    localparam logic [2:0] STEP_DEN = 3'd6;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [2:0]           step_reg;

    // running state of the current set
    logic [CNT_W-1:0]     count_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SQ_W-1:0]      sq_sum_reg;
    logic                 exceeded_reg;
    logic                 few_reg;

    // working registers
    logic [MUL_W-1:0]     x_reg;
    logic                 last_reg;
    logic [2*MUL_W-1:0]   prod_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [MUL_W-1:0]     d_reg;

    logic                 m_valid_reg;
    sva_pkg::sva_out_t    m_item_reg;

    logic                 s_beat;
    logic                 out_free;
    logic                 over_limit;
    logic [MUL_W-1:0]     mul_a;
    logic [MUL_W-1:0]     mul_b;
    logic [ACC_W-1:0]     term;
    logic                 term_sub;
    logic                 div_start;
    sva_pkg::sva_div_stat_t div_stat;
    logic [NUM_W-1:0]     quotient;
    logic [NUM_W+FO_W-1:0] quot_ext;
    sva_pkg::sva_out_t    result;

    assign s_ready    = (state_reg == S_IDLE);
    assign s_beat     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign over_limit = (count_reg >= CNT_W'(sva_pkg::MAX_SAMPLES));
    assign div_start  = (state_reg == S_MAC) && (step_reg == STEP_DEN);

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_beat) begin
                    if (!over_limit) begin
                        state_next = S_SQ;
                    end else if (s_item.last) begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_SQ:    state_next = S_ACC;
            S_ACC:   state_next = last_reg ? S_CHECK : S_IDLE;
            S_CHECK: state_next = (count_reg < CNT_W'(2)) ? S_FIN : S_MUL;
            S_MUL:   state_next = S_MAC;
            S_MAC:   state_next = (step_reg == STEP_DEN) ? S_DIV : S_MUL;
            S_DIV: begin
                if (div_stat.done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = x_reg;
        mul_b = x_reg;
        if (state_reg == S_MUL) begin
            case (step_reg)
                STEP_NS0: begin
                    mul_a = MUL_W'(count_reg);
                    mul_b = sq_sum_reg[31:0];
                end
                STEP_NS1: begin
                    mul_a = MUL_W'(count_reg);
                    mul_b = sq_sum_reg[63:32];
                end
                STEP_NS2: begin
                    mul_a = MUL_W'(count_reg);
                    mul_b = MUL_W'(sq_sum_reg[79:64]);
                end
                STEP_SS0: begin
                    mul_a = sum_reg[31:0];
                    mul_b = sum_reg[31:0];
                end
                STEP_SS1: begin
                    mul_a = sum_reg[31:0];
                    mul_b = MUL_W'(sum_reg[47:32]);
                end
                STEP_SS2: begin
                    mul_a = MUL_W'(sum_reg[47:32]);
                    mul_b = MUL_W'(sum_reg[47:32]);
                end
                STEP_DEN: begin
                    mul_a = MUL_W'(count_reg);
                    mul_b = MUL_W'(count_reg - CNT_W'(1));
                end
                default: begin
                    mul_a = x_reg;
                    mul_b = x_reg;
                end
            endcase
        end
    end

    // partial product placed at its limb weight; the sum^2 cross term counts twice
    always_comb begin
        term     = '0;
        term_sub = 1'b0;
        case (step_reg)
            STEP_NS0: term = ACC_W'(prod_reg);
            STEP_NS1: term = ACC_W'({prod_reg, 32'b0});
            STEP_NS2: term = ACC_W'({prod_reg, 64'b0});
            STEP_SS0: begin
                term     = ACC_W'(prod_reg);
                term_sub = 1'b1;
            end
            STEP_SS1: begin
                term     = ACC_W'({prod_reg, 33'b0});
                term_sub = 1'b1;
            end
            STEP_SS2: begin
                term     = ACC_W'({prod_reg, 64'b0});
                term_sub = 1'b1;
            end
            default: begin
                term     = '0;
                term_sub = 1'b0;
            end
        endcase
    end

    // quotient carries FRAC_BITS fraction bits; the fraction field is left-aligned to 16
    assign quot_ext = {quotient, {FO_W{1'b0}}};

    always_comb begin
        if (few_reg) begin
            result.variance_whole    = '0;
            result.variance_fraction = '0;
            result.status            = sva_pkg::STATUS_FEW;
        end else begin
            result.variance_whole    = quotient[FRAC_BITS +: sva_pkg::WHOLE_W];
            result.variance_fraction = quot_ext[FRAC_BITS +: FO_W];
            result.status            = exceeded_reg ? sva_pkg::STATUS_EXCEEDED
                                                    : sva_pkg::STATUS_OK;
        end
    end

    // control and accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= STEP_NS0;
            count_reg    <= '0;
            sum_reg      <= '0;
            sq_sum_reg   <= '0;
            exceeded_reg <= 1'b0;
            few_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready && !(state_reg == S_FIN && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    // sample beyond the limit is dropped and remembered
                    if (s_beat && over_limit) begin
                        exceeded_reg <= 1'b1;
                    end
                end
                S_ACC: begin
                    sq_sum_reg <= sq_sum_reg + SQ_W'(prod_reg);
                    sum_reg    <= sum_reg + SUM_W'(x_reg);
                    count_reg  <= count_reg + CNT_W'(1);
                end
                S_CHECK: begin
                    few_reg  <= (count_reg < CNT_W'(2));
                    step_reg <= STEP_NS0;
                end
                S_MAC: begin
                    if (step_reg != STEP_DEN) begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                S_FIN: begin
                    // result goes out, set starts afresh
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        count_reg    <= '0;
                        sum_reg      <= '0;
                        sq_sum_reg   <= '0;
                        exceeded_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (s_beat) begin
            x_reg    <= s_item.sample;
            last_reg <= s_item.last;
        end
        if (state_reg == S_CHECK) begin
            acc_reg <= '0;
        end else if (state_reg == S_MAC && step_reg != STEP_DEN) begin
            acc_reg <= term_sub ? (acc_reg - term) : (acc_reg + term);
        end
        if (div_start) begin
            d_reg <= prod_reg[MUL_W-1:0];
        end
        if (state_reg == S_FIN && out_free) begin
            m_item_reg <= result;
        end
    end

    // long division of the scaled numerator by n*(n-1)
    sva_divider #(
        .NUM_W (NUM_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .numerator (NUM_W'(acc_reg) << FRAC_BITS),
        .divisor   (d_reg),
        .stat      (div_stat),
        .quotient  (quotient)
    );

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // set is empty again right after its result is loaded
    a_clear_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && out_free) |=>
            (count_reg == '0 && sum_reg == '0 && sq_sum_reg == '0 && !exceeded_reg))
        else $error("accumulators not cleared after result");

    // count never passes the sample limit
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(sva_pkg::MAX_SAMPLES))
        else $error("sample count beyond limit");

    // a dropped sample only happens with a full set
    a_exceeded_full: assert property (@(posedge aclk) disable iff (!aresetn)
        exceeded_reg |-> (count_reg == CNT_W'(sva_pkg::MAX_SAMPLES)))
        else $error("exceeded flag with a set that is not full");

    // divider is never restarted mid-division
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // short sets report zero variance
    a_few_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status == sva_pkg::STATUS_FEW) |->
            (m_item.variance_whole == '0 && m_item.variance_fraction == '0))
        else $error("short set with nonzero variance");

endmodule

FILE: tb/sample_variance_accumulator_tb.sv
module sample_variance_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W    = sva_pkg::SAMPLE_W;
    localparam int WHOLE_W     = sva_pkg::WHOLE_W;
    localparam int FRAC_OUT_W  = sva_pkg::FRAC_OUT_W;
    localparam int CNT_W       = sva_pkg::CNT_W;
    localparam int SUM_W       = sva_pkg::SUM_W;
    localparam int SQ_W        = sva_pkg::SQ_W;
    localparam int MAX_SAMPLES = sva_pkg::MAX_SAMPLES;
    localparam int FRAC_BITS   = sva_pkg::FRAC_BITS;

    // run limits: durations in clock cycles, then item counts
    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    localparam int unsigned DRAIN_LIMIT   = 50_000;
    localparam int unsigned SETTLE_CYCLES = 400;
    localparam int unsigned LONG_HOLD     = 1500;
    localparam int unsigned RANDOM_ITEMS  = 1150;
    localparam int unsigned STEADY_ITEMS  = 80;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    // receiver behaviour over one stretch
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    // how the samples of one random set are drawn
    typedef enum logic [1:0] {
        SET_WIDE,
        SET_LOW,
        SET_HIGH,
        SET_FLAT
    } set_style_t;

    // one row of the directed table; want only counts where typed is set
    typedef struct packed {
        sva_pkg::sva_in_t  beat;
        logic              typed;
        sva_pkg::sva_out_t want;
    } step_row_t;

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    sva_pkg::sva_in_t  s_item  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    sva_pkg::sva_out_t m_item;

    // predictor state, a copy of the accumulators
    logic [CNT_W-1:0] held_count;
    logic [SUM_W-1:0] held_sum;
    logic [SQ_W-1:0]  held_square_sum;
    logic             held_dropped;

    sva_pkg::sva_out_t variance_queue [$];
    int unsigned mismatches    = 0;
    int unsigned samples_sent  = 0;
    int unsigned sets_closed   = 0;
    int unsigned results_seen  = 0;
    int unsigned cycle_count   = 0;
    int unsigned burst_left    = 1;
    bit          steady        = 1'b0;
    bit          offering      = 1'b0;
    bit          long_hold_armed = 1'b0;

    // directed table: lone samples, tiny sets, a flat small set and a flat set at the top extreme,
    // the widest two-sample spread and a few alternating bit patterns
    step_row_t directed_rows [0:20] = '{
        '{'{32'h0000_002A, 1'b1}, 1'b1, '{63'd0, 16'h0000, sva_pkg::STATUS_FEW}},
        '{'{32'h0000_0000, 1'b1}, 1'b1, '{63'd0, 16'h0000, sva_pkg::STATUS_FEW}},
        '{'{32'h0000_0001, 1'b0}, 1'b0, '0},
        '{'{32'h0000_0002, 1'b1}, 1'b1, '{63'd0, 16'h8000, sva_pkg::STATUS_OK}},
        '{'{32'h0000_0005, 1'b0}, 1'b0, '0},
        '{'{32'h0000_0005, 1'b0}, 1'b0, '0},
        '{'{32'h0000_0005, 1'b1}, 1'b1, '{63'd0, 16'h0000, sva_pkg::STATUS_OK}},
        '{'{SAMPLE_MAX,    1'b0}, 1'b0, '0},
        '{'{SAMPLE_MAX,    1'b0}, 1'b0, '0},
        '{'{SAMPLE_MAX,    1'b1}, 1'b1, '{63'd0, 16'h0000, sva_pkg::STATUS_OK}},
        '{'{32'h0000_0000, 1'b0}, 1'b0, '0},
        '{'{SAMPLE_MAX,    1'b1}, 1'b0, '0},
        '{'{32'h0000_0001, 1'b0}, 1'b0, '0},
        '{'{32'h0000_0002, 1'b0}, 1'b0, '0},
        '{'{32'h0000_0003, 1'b0}, 1'b0, '0},
        '{'{32'h0000_0004, 1'b1}, 1'b0, '0},
        '{'{32'hAAAA_AAAA, 1'b0}, 1'b0, '0},
        '{'{32'h5555_5555, 1'b0}, 1'b0, '0},
        '{'{32'h8000_0000, 1'b0}, 1'b0, '0},
        '{'{32'h7FFF_FFFF, 1'b1}, 1'b0, '0},
        '{'{SAMPLE_MAX,    1'b1}, 1'b1, '{63'd0, 16'h0000, sva_pkg::STATUS_FEW}}
    };

    sample_variance_accumulator DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // folds one sample into the copied accumulators; on a last beat works out
    // the exact variance in fixed point and clears the set
    function automatic bit predict_variance(input sva_pkg::sva_in_t beat,
                                            output sva_pkg::sva_out_t res);
        logic [127:0] spread;
        logic [127:0] divisor;
        logic [127:0] quotient;
        logic [127:0] frac_wide;
        res = '0;
        if (held_count >= CNT_W'(MAX_SAMPLES)) begin
            // already full, the sample is dropped but remembered
            held_dropped = 1'b1;
        end else begin
            held_square_sum = held_square_sum + SQ_W'(beat.sample) * SQ_W'(beat.sample);
            held_sum        = held_sum + SUM_W'(beat.sample);
            held_count      = held_count + CNT_W'(1);
        end
        if (!beat.last) begin
            return 1'b0;
        end
        if (held_count < CNT_W'(2)) begin
            res.status = sva_pkg::STATUS_FEW;
        end else begin
            spread    = 128'(held_count) * 128'(held_square_sum)
                      - 128'(held_sum) * 128'(held_sum);
            spread    = spread << FRAC_BITS;
            divisor   = 128'(held_count) * (128'(held_count) - 128'd1);
            quotient  = spread / divisor;
            frac_wide = ((quotient & ((128'd1 << FRAC_BITS) - 128'd1)) << 16) >> FRAC_BITS;
            res.variance_whole    = WHOLE_W'(quotient >> FRAC_BITS);
            res.variance_fraction = frac_wide[FRAC_OUT_W-1:0];
            res.status            = held_dropped ? sva_pkg::STATUS_EXCEEDED
                                                 : sva_pkg::STATUS_OK;
        end
        held_count      = '0;
        held_sum        = '0;
        held_square_sum = '0;
        held_dropped    = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // offers one beat, holds it until taken, then maybe drops valid for a gap;
    // a typed expectation replaces the predicted one for that set
    task automatic send_sample(input sva_pkg::sva_in_t beat, input bit typed,
                               input sva_pkg::sva_out_t typed_want);
        sva_pkg::sva_out_t predicted;
        s_item   <= beat;
        s_valid  <= 1'b1;
        offering = 1'b1;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
        if (predict_variance(beat, predicted)) begin
            variance_queue.push_back(typed ? typed_want : predicted);
            sets_closed++;
        end
        if (!steady) begin
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
                // wait before raising valid again, so valid never drops and rises in one step
                s_valid  <= 1'b0;
                offering = 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 16);
            end
        end
    endtask

    // receiver: stretches of differing readiness, plus one long hold-off on request
    initial begin
        rx_mode_t    mode;
        int unsigned stretch;
        @(posedge aclk);
        forever begin
            if (long_hold_armed) begin
                // result register stays full, so the block has to stall its input
                long_hold_armed = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                mode    = rx_mode_t'($urandom_range(0, 3));
                stretch = $urandom_range(10, 150);
                repeat (stretch) begin
                    case (mode)
                        RX_OPEN:   m_ready <= 1'b1;
                        RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                        RX_SPARSE: m_ready <= ($urandom_range(0, 5) == 0);
                        default:   m_ready <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    // result checker: oldest expectation against each accepted result beat
    always @(posedge aclk) begin
        sva_pkg::sva_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (variance_queue.size() == 0) begin
                report_mismatch("unexpected result, status", 64'(m_item.status), 64'd0);
            end else begin
                want = variance_queue.pop_front();
                if (m_item.variance_whole !== want.variance_whole)
                    report_mismatch("variance_whole", 64'(m_item.variance_whole),
                                    64'(want.variance_whole));
                if (m_item.variance_fraction !== want.variance_fraction)
                    report_mismatch("variance_fraction", 64'(m_item.variance_fraction),
                                    64'(want.variance_fraction));
                if (m_item.status !== want.status)
                    report_mismatch("status", 64'(m_item.status), 64'(want.status));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, variance_queue.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        sva_pkg::sva_in_t    beat;
        set_style_t          style;
        int unsigned         set_len;
        int unsigned         random_sent;
        int unsigned         drain;
        logic [SAMPLE_W-1:0] flat_value;

        held_count      = '0;
        held_sum        = '0;
        held_square_sum = '0;
        held_dropped    = 1'b0;

        // synchronous reset, held active before release
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (directed_rows[i])
            send_sample(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

        // random sets; the long hold-off lands early while beats keep coming
        long_hold_armed = 1'b1;
        random_sent     = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       set_len = 1;
                1:       set_len = $urandom_range(20, 150);
                default: set_len = $urandom_range(2, 10);
            endcase
            style      = set_style_t'($urandom_range(0, 3));
            flat_value = $urandom;
            for (int unsigned k = 0; k < set_len; k++) begin
                case (style)
                    SET_WIDE: beat.sample = $urandom;
                    SET_LOW:  beat.sample = $urandom_range(0, 15);
                    SET_HIGH: beat.sample = SAMPLE_MAX - $urandom_range(0, 15);
                    default:  beat.sample = flat_value;
                endcase
                beat.last = (k == set_len - 1);
                send_sample(beat, 1'b0, '0);
                random_sent++;
            end
        end

        // one set back to back with no sender gaps, alternating extremes
        steady = 1'b1;
        for (int unsigned k = 0; k < STEADY_ITEMS; k++) begin
            beat.sample = k[0] ? '0 : SAMPLE_MAX;
            beat.last   = (k == STEADY_ITEMS - 1);
            send_sample(beat, 1'b0, '0);
        end
        if (offering) begin
            s_valid  <= 1'b0;
            offering = 1'b0;
        end

        // drain, then settle long enough for a stray result to show
        drain = 0;
        while (variance_queue.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (variance_queue.size() != 0)
            report_mismatch("results never arrived, count", 64'(variance_queue.size()), 64'd0);

        $display("%0d samples in %0d sets, %0d results compared, over %0d cycles",
                 samples_sent, sets_closed, results_seen, cycle_count);
        $display("included lone samples, flat and extreme sets, a long receiver hold-off "
                 , "and a gapless set of alternating extremes");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
